### src/crst_pkg.sv
`timescale 1ns / 1ps

package crst_pkg;

    localparam int HS_LEN    = 7;
    localparam int DATA_HDR  = 9;
    localparam int IDX_W     = 17;
    localparam logic [IDX_W-1:0] IDX_MAX = '1;
    localparam logic [7:0] TYPE_HS   = 8'd1;
    localparam logic [7:0] TYPE_DATA = 8'd2;

    localparam logic [1:0] FUNC_PKT  = 2'd0;
    localparam logic [1:0] FUNC_READ = 2'd1;
    localparam logic [1:0] FUNC_REL  = 2'd2;

    localparam logic [2:0] KIND_DROP   = 3'd0;
    localparam logic [2:0] KIND_OPEN   = 3'd1;
    localparam logic [2:0] KIND_CHUNK  = 3'd2;
    localparam logic [2:0] KIND_DONE   = 3'd3;
    localparam logic [2:0] KIND_READ   = 3'd4;
    localparam logic [2:0] KIND_REL    = 3'd5;

    typedef enum logic [1:0] {
        OP_PKT,
        OP_READ,
        OP_REL,
        OP_NONE
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [7:0]  pkt_byte;
        logic        pkt_last;
        logic [2:0]  slot;
        logic [11:0] read_offset;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_qhead;

endpackage

### src/crst_ram.sv
`timescale 1ns / 1ps

module crst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32768
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/crst_front.sv
`timescale 1ns / 1ps

module crst_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [1:0]        i_func,
    input  logic [7:0]        i_pkt_byte,
    input  logic              i_pkt_last,
    input  logic [2:0]        i_slot,
    input  logic [11:0]       i_read_offset,
    output logic              o_full,
    output crst_pkg::t_qhead  o_head,
    input  logic              i_take
);
    import crst_pkg::*;

    t_item      r_q [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_cnt;
    t_item      w_item;
    logic       w_enq;

    always_comb begin
        w_item.pkt_byte    = i_pkt_byte;
        w_item.pkt_last    = i_pkt_last;
        w_item.slot        = i_slot;
        w_item.read_offset = i_read_offset;
        unique case (i_func)
            FUNC_PKT:  w_item.op = OP_PKT;
            FUNC_READ: w_item.op = OP_READ;
            FUNC_REL:  w_item.op = OP_REL;
            default:   w_item.op = OP_NONE;
        endcase
    end

    // Items without meaning are consumed here and never queued.
    assign o_full = (r_cnt == 2'd2);
    assign w_enq  = i_push && !o_full && (w_item.op != OP_NONE);

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.item  = r_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (w_enq) begin
                r_q[r_wptr] <= w_item;
                r_wptr      <= !r_wptr;
            end
            if (i_take) begin
                r_rptr <= !r_rptr;
            end
            r_cnt <= r_cnt + 2'(w_enq) - 2'(i_take);
        end
    end

endmodule

### src/crst_back.sv
`timescale 1ns / 1ps

module crst_back #(
    parameter int SESSIONS  = 8,
    parameter int MSG_BYTES = 4096
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  crst_pkg::t_qhead                      i_head,
    output logic                                  o_take,
    output logic                                  o_we,
    output logic [$clog2(SESSIONS*MSG_BYTES)-1:0] o_waddr,
    output logic [7:0]                            o_wdata,
    output logic [$clog2(SESSIONS*MSG_BYTES)-1:0] o_raddr,
    input  logic [7:0]                            i_rdata,
    output logic                                  o_empty,
    input  logic                                  i_pop,
    output logic [2:0]                            o_kind,
    output logic [2:0]                            o_result_slot,
    output logic [12:0]                           o_msg_length,
    output logic [7:0]                            o_read_byte
);
    import crst_pkg::*;

    localparam int SW = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
    localparam int LW = $clog2(MSG_BYTES + 1);
    localparam int AW = $clog2(SESSIONS * MSG_BYTES);

    typedef enum logic {ST_RUN, ST_READ} t_state;

    t_state           r_state;
    logic [31:0]      r_sid   [SESSIONS];
    logic [LW-1:0]    r_slen  [SESSIONS];
    logic [LW-1:0]    r_exp   [SESSIONS];
    logic [SESSIONS-1:0] r_done;
    logic [63:0]      r_hdr;
    logic [IDX_W-1:0] r_idx;
    logic             r_pok;
    logic [7:0]       r_ptype;
    logic [SW-1:0]    r_cslot;
    logic             r_out_valid;
    logic [2:0]       r_kind;
    logic [2:0]       r_rslot;
    logic [12:0]      r_len;
    logic [7:0]       r_rbyte;

    logic [31:0]      n_sid   [SESSIONS];
    logic [LW-1:0]    n_slen  [SESSIONS];
    logic [LW-1:0]    n_exp   [SESSIONS];
    logic [SESSIONS-1:0] n_done;
    logic [63:0]      n_hdr;
    logic [IDX_W-1:0] n_idx;
    logic             n_pok;
    logic [7:0]       n_ptype;
    logic [SW-1:0]    n_cslot;

    t_item            w_it;
    logic             w_res;
    logic             w_rd_go;
    logic [2:0]       w_kind;
    logic [2:0]       w_rslot;
    logic [12:0]      w_len;
    logic [IDX_W-1:0] w_count;
    logic [IDX_W-1:0] w_pos;
    logic [31:0]      w_key;
    logic             w_found;
    logic [SW-1:0]    w_fidx;
    logic             w_free;
    logic [SW-1:0]    w_freeidx;
    logic [SW-1:0]    w_sidx;
    logic             w_sok;
    logic [15:0]      w_off;
    logic [15:0]      w_size;
    logic [15:0]      w_hlen;
    logic [SW-1:0]    w_k;

    assign w_it    = i_head.item;
    assign o_take  = i_head.valid && (r_state == ST_RUN) && (!r_out_valid || i_pop);
    assign w_sidx  = SW'(w_it.slot);
    assign w_sok   = (32'(w_it.slot) < SESSIONS);
    assign o_raddr = AW'(32'(w_sidx) * MSG_BYTES + 32'(w_it.read_offset));

    always_comb begin
        n_sid   = r_sid;
        n_slen  = r_slen;
        n_exp   = r_exp;
        n_done  = r_done;
        n_hdr   = r_hdr;
        n_idx   = r_idx;
        n_pok   = r_pok;
        n_ptype = r_ptype;
        n_cslot = r_cslot;
        w_res   = 1'b0;
        w_rd_go = 1'b0;
        w_kind  = KIND_DROP;
        w_rslot = 3'd0;
        w_len   = 13'd0;
        o_we    = 1'b0;
        o_wdata = w_it.pkt_byte;
        w_pos   = r_idx - IDX_W'(DATA_HDR);
        o_waddr = AW'(32'(r_cslot) * MSG_BYTES + 32'(r_hdr[31:16]) + 32'(w_pos));
        w_count = (r_idx == IDX_MAX) ? IDX_MAX : r_idx + 1'b1;

        if (r_idx == '0) begin
            n_ptype = w_it.pkt_byte;
        end else if (r_idx < IDX_W'(DATA_HDR)) begin
            n_hdr = {r_hdr[55:0], w_it.pkt_byte};
        end else if (r_pok && (32'(w_pos) < 32'(r_hdr[15:0]))
                     && (32'(r_hdr[31:16]) + 32'(w_pos) < MSG_BYTES)) begin
            o_we = o_take && (w_it.op == OP_PKT);
        end

        w_off  = n_hdr[31:16];
        w_size = n_hdr[15:0];
        w_hlen = n_hdr[15:0];
        w_key  = (w_count == IDX_W'(HS_LEN)) ? n_hdr[47:16] : n_hdr[63:32];

        w_found = 1'b0;
        w_fidx  = '0;
        w_free  = 1'b0;
        w_freeidx = '0;
        for (int k = SESSIONS - 1; k >= 0; k--) begin
            if (w_key != 32'd0 && r_sid[k] == w_key) begin
                w_found = 1'b1;
                w_fidx  = SW'(k);
            end
            if (r_sid[k] == 32'd0) begin
                w_free    = 1'b1;
                w_freeidx = SW'(k);
            end
        end

        if (w_count == IDX_W'(DATA_HDR) && n_ptype == TYPE_DATA) begin
            n_pok = w_found && !r_done[w_fidx] && (32'(w_off) == 32'(r_exp[w_fidx]))
                    && (32'(w_off) + 32'(w_size) <= 32'(r_slen[w_fidx]));
            n_cslot = w_found ? w_fidx : '0;
        end
        w_k = n_cslot;

        if (w_it.pkt_last) begin
            w_res = 1'b1;
            if (n_ptype == TYPE_HS && w_count == IDX_W'(HS_LEN)) begin
                if (!w_found && w_key != 32'd0 && 32'(w_hlen) <= MSG_BYTES && w_free) begin
                    n_sid[w_freeidx]  = w_key;
                    n_slen[w_freeidx] = LW'(w_hlen);
                    n_exp[w_freeidx]  = '0;
                    n_done[w_freeidx] = 1'b0;
                    w_kind  = KIND_OPEN;
                    w_rslot = 3'(w_freeidx);
                    w_len   = 13'(w_hlen);
                end
            end else if (n_ptype == TYPE_DATA && w_count >= IDX_W'(DATA_HDR) && n_pok) begin
                if (n_hdr[63:32] != 32'd0 && r_sid[w_k] == n_hdr[63:32] && !r_done[w_k]
                    && (32'(w_off) == 32'(r_exp[w_k]))
                    && (32'(w_off) + 32'(w_size) <= 32'(r_slen[w_k]))
                    && (32'(w_count) - DATA_HDR >= 32'(w_size))) begin
                    n_exp[w_k] = LW'(32'(w_off) + 32'(w_size));
                    w_rslot    = 3'(w_k);
                    w_len      = 13'(r_slen[w_k]);
                    if (32'(w_off) + 32'(w_size) == 32'(r_slen[w_k])) begin
                        n_done[w_k] = 1'b1;
                        w_kind      = KIND_DONE;
                    end else begin
                        w_kind = KIND_CHUNK;
                    end
                end
            end
            n_idx   = '0;
            n_pok   = 1'b0;
            n_hdr   = '0;
            n_ptype = '0;
            n_cslot = '0;
        end else begin
            n_idx = w_count;
        end

        // Read and release requests leave the packet parser untouched.
        if (w_it.op != OP_PKT) begin
            n_sid   = r_sid;
            n_slen  = r_slen;
            n_exp   = r_exp;
            n_done  = r_done;
            n_hdr   = r_hdr;
            n_idx   = r_idx;
            n_pok   = r_pok;
            n_ptype = r_ptype;
            n_cslot = r_cslot;
            w_res   = 1'b1;
            w_kind  = KIND_DROP;
            w_rslot = w_it.slot;
            w_len   = w_sok ? 13'(r_slen[w_sidx]) : 13'd0;
            if (w_it.op == OP_READ) begin
                w_rd_go = w_sok && r_done[w_sidx]
                          && (32'(w_it.read_offset) < 32'(r_slen[w_sidx]))
                          && (32'(w_it.read_offset) < MSG_BYTES);
                w_res   = !w_rd_go;
                w_kind  = KIND_READ;
                if (!w_rd_go) begin
                    w_kind = KIND_DROP;
                end
            end else if (w_sok) begin
                w_kind         = KIND_REL;
                n_sid[w_sidx]  = '0;
                n_slen[w_sidx] = '0;
                n_exp[w_sidx]  = '0;
                n_done[w_sidx] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_done      <= '0;
            r_hdr       <= '0;
            r_idx       <= '0;
            r_pok       <= 1'b0;
            r_ptype     <= '0;
            r_cslot     <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < SESSIONS; k++) begin
                r_sid[k]  <= '0;
                r_slen[k] <= '0;
                r_exp[k]  <= '0;
            end
        end else begin
            unique case (r_state)
                ST_RUN: begin
                    if (i_pop) begin
                        r_out_valid <= 1'b0;
                    end
                    if (o_take) begin
                        r_sid   <= n_sid;
                        r_slen  <= n_slen;
                        r_exp   <= n_exp;
                        r_done  <= n_done;
                        r_hdr   <= n_hdr;
                        r_idx   <= n_idx;
                        r_pok   <= n_pok;
                        r_ptype <= n_ptype;
                        r_cslot <= n_cslot;
                        r_kind  <= w_kind;
                        r_rslot <= w_rslot;
                        r_len   <= w_len;
                        r_rbyte <= 8'd0;
                        if (w_res) begin
                            r_out_valid <= 1'b1;
                        end
                        if (w_rd_go) begin
                            r_state <= ST_READ;
                        end
                    end
                end
                ST_READ: begin
                    r_rbyte     <= i_rdata;
                    r_out_valid <= 1'b1;
                    r_state     <= ST_RUN;
                end
                default: r_state <= ST_RUN;
            endcase
        end
    end

    assign o_empty       = !r_out_valid;
    assign o_kind        = r_kind;
    assign o_result_slot = r_rslot;
    assign o_msg_length  = r_len;
    assign o_read_byte   = r_rbyte;

endmodule

### src/chunk_reassembly_session_table_core.sv
`timescale 1ns / 1ps

// Channel   Handshake           Payload
// input     push / full         i_func, i_pkt_byte, i_pkt_last, i_slot, i_read_offset
// result    empty / pop         o_kind, o_result_slot, o_msg_length, o_read_byte
//
// A packet byte or release word is handled in ST_RUN alone; an accepted read word passes through
// ST_RUN and then ST_READ, set by the registered read port of the message store.
// A two-entry queue separates intake from execution, so push is taken while a result waits, unless full.
// The executor takes the next word only once the result register is free or being popped.
// Reset is synchronous and frees all sessions at once; the message store is not cleared.

module chunk_reassembly_session_table_core #(
    parameter int SESSIONS  = 8,
    parameter int MSG_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_pkt_byte,
    input  logic        i_pkt_last,
    input  logic [2:0]  i_slot,
    input  logic [11:0] i_read_offset,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_kind,
    output logic [2:0]  o_result_slot,
    output logic [12:0] o_msg_length,
    output logic [7:0]  o_read_byte
);
    import crst_pkg::*;

    localparam int DEPTH = SESSIONS * MSG_BYTES;
    localparam int AW    = $clog2(DEPTH);

    t_qhead        w_head;
    logic          w_take;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [AW-1:0] w_raddr;
    logic [7:0]    w_wdata;
    logic [7:0]    w_rdata;

    crst_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_func        (i_func),
        .i_pkt_byte    (i_pkt_byte),
        .i_pkt_last    (i_pkt_last),
        .i_slot        (i_slot),
        .i_read_offset (i_read_offset),
        .o_full        (full),
        .o_head        (w_head),
        .i_take        (w_take)
    );

    crst_back #(
        .SESSIONS  (SESSIONS),
        .MSG_BYTES (MSG_BYTES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .o_take        (w_take),
        .o_we          (w_we),
        .o_waddr       (w_waddr),
        .o_wdata       (w_wdata),
        .o_raddr       (w_raddr),
        .i_rdata       (w_rdata),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_kind        (o_kind),
        .o_result_slot (o_result_slot),
        .o_msg_length  (o_msg_length),
        .o_read_byte   (o_read_byte)
    );

    crst_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

`ifndef SYNTHESIS
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_kind <= KIND_REL)
        else $error("result kind out of range");
    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_kind != KIND_READ |-> o_read_byte == 8'd0)
        else $error("read byte set on a non-read result");
    a_take_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> w_head.valid)
        else $error("executor took from an empty queue");
`endif

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import crst_pkg::*;

    localparam int NSESS   = 8;
    localparam int MSGSIZE = 4096;
    localparam int LIMIT   = 3000000;

    typedef struct {
        logic [2:0]  kind;
        logic [2:0]  slot;
        logic [12:0] len;
        logic [7:0]  rbyte;
    } t_res;

    class t_scoreboard;
        logic [31:0] sess_id[NSESS];
        logic [12:0] sess_len[NSESS];
        logic [12:0] next_off[NSESS];
        logic        sess_done[NSESS];
        logic [7:0]  msg_mem[NSESS*MSGSIZE];
        logic [63:0] hdr;
        int          byte_idx;
        logic        pay_ok;
        logic [7:0]  ptype;
        int          chunk_slot;
        t_res        pending[$];
        int          errors;

        function void clear();
            for (int k = 0; k < NSESS; k++) begin
                sess_id[k] = 0;
                sess_len[k] = 0;
                next_off[k] = 0;
                sess_done[k] = 0;
            end
            hdr = 0;
            byte_idx = 0;
            pay_ok = 0;
            ptype = 0;
            chunk_slot = 0;
            errors = 0;
        endfunction

        function int find_id(logic [31:0] id);
            if (id == 0) return -1;
            for (int k = 0; k < NSESS; k++)
                if (sess_id[k] == id) return k;
            return -1;
        endfunction

        function bit fits(int k, int off, int size);
            return !sess_done[k] && off == next_off[k] && off + size <= sess_len[k];
        endfunction

        function void expect_res(logic [2:0] kind, int s, int len, logic [7:0] b);
            t_res r;
            r.kind = kind;
            r.slot = s[2:0];
            r.len = len[12:0];
            r.rbyte = b;
            pending.push_back(r);
        endfunction

        function void close_packet(int count);
            int id, off, size, k;
            if (ptype == TYPE_HS && count == HS_LEN) begin
                id = hdr[47:16];
                size = hdr[15:0];
                k = -1;
                if (id != 0 && find_id(id) < 0 && size <= MSGSIZE)
                    for (int j = NSESS - 1; j >= 0; j--)
                        if (sess_id[j] == 0) k = j;
                if (k < 0) begin
                    expect_res(KIND_DROP, 0, 0, 0);
                end else begin
                    sess_id[k] = id;
                    sess_len[k] = size;
                    next_off[k] = 0;
                    sess_done[k] = 0;
                    expect_res(KIND_OPEN, k, size, 0);
                end
                return;
            end
            if (ptype == TYPE_DATA && count >= DATA_HDR && pay_ok) begin
                id = hdr[63:32];
                off = hdr[31:16];
                size = hdr[15:0];
                k = chunk_slot;
                if (id != 0 && sess_id[k] == id && fits(k, off, size)
                        && count - DATA_HDR >= size) begin
                    next_off[k] = off + size;
                    if (next_off[k] == sess_len[k]) begin
                        sess_done[k] = 1;
                        expect_res(KIND_DONE, k, sess_len[k], 0);
                    end else begin
                        expect_res(KIND_CHUNK, k, sess_len[k], 0);
                    end
                    return;
                end
            end
            expect_res(KIND_DROP, 0, 0, 0);
        endfunction

        function void note(logic [1:0] func, logic [7:0] b, logic last, logic [2:0] s,
                           logic [11:0] roff);
            int count, pos, k;
            if (func == FUNC_PKT) begin
                if (byte_idx == 0) begin
                    ptype = b;
                end else if (byte_idx < DATA_HDR) begin
                    hdr = {hdr[55:0], b};
                end else if (pay_ok) begin
                    pos = byte_idx - DATA_HDR;
                    if (pos < hdr[15:0] && hdr[31:16] + pos < MSGSIZE)
                        msg_mem[chunk_slot*MSGSIZE + hdr[31:16] + pos] = b;
                end
                count = (byte_idx < int'(IDX_MAX)) ? byte_idx + 1 : int'(IDX_MAX);
                if (count == DATA_HDR && ptype == TYPE_DATA) begin
                    k = find_id(hdr[63:32]);
                    pay_ok = (k >= 0) && fits(k, hdr[31:16], hdr[15:0]);
                    chunk_slot = (k >= 0) ? k : 0;
                end
                if (last) begin
                    close_packet(count);
                    byte_idx = 0;
                    pay_ok = 0;
                    hdr = 0;
                    ptype = 0;
                    chunk_slot = 0;
                end else begin
                    byte_idx = count;
                end
            end else if (func == FUNC_READ) begin
                if (!sess_done[s] || roff >= sess_len[s])
                    expect_res(KIND_DROP, s, sess_len[s], 0);
                else
                    expect_res(KIND_READ, s, sess_len[s], msg_mem[s*MSGSIZE + roff]);
            end else if (func == FUNC_REL) begin
                expect_res(KIND_REL, s, sess_len[s], 0);
                sess_id[s] = 0;
                sess_len[s] = 0;
                next_off[s] = 0;
                sess_done[s] = 0;
            end
        endfunction

        function void check(t_res act);
            t_res e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word kind %0d slot %0d len %0d byte %0d",
                         $time, act.kind, act.slot, act.len, act.rbyte);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (act.kind !== e.kind) begin
                $display("%0t: kind expected %0d actual %0d", $time, e.kind, act.kind);
                errors++;
            end
            if (act.slot !== e.slot) begin
                $display("%0t: slot expected %0d actual %0d", $time, e.slot, act.slot);
                errors++;
            end
            if (act.len !== e.len) begin
                $display("%0t: length expected %0d actual %0d", $time, e.len, act.len);
                errors++;
            end
            if (act.rbyte !== e.rbyte) begin
                $display("%0t: byte expected %0d actual %0d", $time, e.rbyte, act.rbyte);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        push = 0;
    logic        full;
    logic [1:0]  i_func = FUNC_PKT;
    logic [7:0]  i_pkt_byte = 0;
    logic        i_pkt_last = 0;
    logic [2:0]  i_slot = 0;
    logic [11:0] i_read_offset = 0;
    logic        empty;
    logic        pop = 0;
    logic [2:0]  o_kind;
    logic [2:0]  o_result_slot;
    logic [12:0] o_msg_length;
    logic [7:0]  o_read_byte;

    t_scoreboard sb = new();
    int  words = 0;
    int  cycles = 0;
    int  pop_hold = 0;
    bit  steady = 0;
    bit  running = 0;

    chunk_reassembly_session_table_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_func(i_func), .i_pkt_byte(i_pkt_byte), .i_pkt_last(i_pkt_last),
        .i_slot(i_slot), .i_read_offset(i_read_offset), .empty(empty), .pop(pop),
        .o_kind(o_kind), .o_result_slot(o_result_slot), .o_msg_length(o_msg_length),
        .o_read_byte(o_read_byte)
    );

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_res r;
        int   pick;
        if (running && pop && !empty) begin
            r.kind = o_kind;
            r.slot = o_result_slot;
            r.len = o_msg_length;
            r.rbyte = o_read_byte;
            sb.check(r);
        end
        pick = $urandom_range(0, 99);
        if (!running) begin
            pop <= 0;
        end else if (steady) begin
            pop <= 1;
        end else if (pop_hold > 0) begin
            pop_hold <= pop_hold - 1;
            pop <= 0;
        end else if (pick < 65) begin
            pop <= 1;
        end else if (pick < 95) begin
            pop <= 0;
            pop_hold <= $urandom_range(0, 3);
        end else begin
            pop <= 0;
            pop_hold <= $urandom_range(10, 40);
        end
    end

    function int gap_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (steady || pick < 70) return 0;
        if (pick < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_word(logic [1:0] func, logic [7:0] b, logic last, logic [2:0] s,
                             logic [11:0] roff);
        int g;
        i_func <= func;
        i_pkt_byte <= b;
        i_pkt_last <= last;
        i_slot <= s;
        i_read_offset <= roff;
        push <= 1;
        do @(posedge i_clk); while (full);
        sb.note(func, b, last, s, roff);
        words++;
        g = gap_len();
        if (g > 0) begin
            push <= 0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic send_bytes(logic [7:0] q[$], bit hold_last);
        for (int j = 0; j < q.size(); j++)
            if (!(hold_last && j == q.size() - 1))
                send_word(FUNC_PKT, q[j], j == q.size() - 1, $urandom, $urandom);
    endtask

    function automatic void build_hs(ref logic [7:0] q[$], input logic [31:0] id,
                                     input logic [15:0] len);
        q = {TYPE_HS, id[31:24], id[23:16], id[15:8], id[7:0], len[15:8], len[7:0]};
    endfunction

    function automatic void build_data(ref logic [7:0] q[$], input logic [31:0] id,
                                       input logic [15:0] off, input logic [15:0] size,
                                       input int payload);
        q = {TYPE_DATA, id[31:24], id[23:16], id[15:8], id[7:0],
             off[15:8], off[7:0], size[15:8], size[7:0]};
        repeat (payload) q.push_back($urandom);
    endfunction

    task automatic handshake(logic [31:0] id, logic [15:0] len);
        logic [7:0] q[$];
        build_hs(q, id, len);
        send_bytes(q, 0);
    endtask

    task automatic chunk(logic [31:0] id, logic [15:0] off, logic [15:0] size, int extra);
        logic [7:0] q[$];
        build_data(q, id, off, size, size + extra);
        send_bytes(q, 0);
    endtask

    task automatic drain();
        push <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic directed();
        logic [7:0] q[$];
        send_word(OP_NONE, 8'hFF, 1, 3'd7, 12'hFFF);
        handshake(32'd0, 16'd5);
        handshake(32'hFFFF_FFFF, 16'd4097);
        build_hs(q, 32'd9, 16'd3);
        q.pop_back();
        send_bytes(q, 0);
        build_data(q, 32'd9, 0, 0, 0);
        q[0] = 8'd3;
        send_bytes(q, 0);
        handshake(32'hA5A5_5A5A, 16'd0);
        chunk(32'hA5A5_5A5A, 0, 0, 0);
        send_word(FUNC_READ, 0, 0, 3'd0, 12'd0);
        steady = 1;
        handshake(32'hFFFF_FFFF, 16'd4096);
        handshake(32'hFFFF_FFFF, 16'd8);
        chunk(32'hFFFF_FFFF, 16'd4, 16'd4, 0);
        chunk(32'hFFFF_FFFF, 0, 16'd24, -1);
        chunk(32'hFFFF_FFFF, 0, 16'd24, 3);
        chunk(32'hFFFF_FFFF, 16'd4096, 0, 0);
        steady = 0;
        send_word(FUNC_READ, 0, 1, 3'd1, 12'd0);
        send_word(FUNC_READ, 0, 1, 3'd1, 12'hFFF);
        send_word(FUNC_READ, 0, 1, 3'd1, 12'hAAA);
        send_word(FUNC_READ, 0, 1, 3'd1, 12'h555);
        send_word(FUNC_READ, 0, 0, 3'd7, 12'd1);
        send_word(FUNC_REL, 0, 0, 3'd7, 12'd0);
        handshake(32'd5, 16'd20);
        build_data(q, 32'd5, 0, 16'd10, 10);
        send_bytes(q, 1);
        send_word(FUNC_REL, 0, 0, 3'd2, 12'd0);
        send_word(FUNC_PKT, q[q.size()-1], 1, 0, 0);
        chunk(32'd0, 0, 0, 0);
        chunk(32'h1234_5678, 0, 1, 0);
        for (int k = 0; k < NSESS + 1; k++)
            handshake(32'h100 + k, 16'd4);
        for (int k = 0; k < NSESS; k++)
            send_word(FUNC_REL, 0, 0, k, 12'd0);
        drain();
    endtask

    task automatic random_phase();
        logic [7:0] q[$];
        int pick, k, rem, size, n;
        logic [31:0] id;
        while (words < 900) begin
            pick = $urandom_range(0, 99);
            k = -1;
            n = $urandom_range(0, NSESS - 1);
            for (int j = 0; j < NSESS; j++)
                if (sb.sess_id[(n+j)%NSESS] != 0 && !sb.sess_done[(n+j)%NSESS] && k < 0)
                    k = (n + j) % NSESS;
            if (pick < 8) steady = !steady;
            if (pick < 45 && k >= 0) begin
                rem = sb.sess_len[k] - sb.next_off[k];
                size = $urandom_range(0, rem < 16 ? rem : (rem < 600 ? 16 : 400));
                if ($urandom_range(0, 9) == 0) begin
                    chunk(sb.sess_id[k], sb.next_off[k] + $urandom_range(0, 2),
                          size + $urandom_range(0, 1), $urandom_range(0, 2) - 1);
                end else begin
                    chunk(sb.sess_id[k], sb.next_off[k], size,
                          $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0);
                end
            end else if (pick < 65) begin
                id = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 14);
                n = $urandom_range(0, 99);
                handshake(id, n < 5 ? 16'($urandom) : n < 10 ? 16'($urandom_range(200, 4096))
                          : 16'($urandom_range(0, 40)));
            end else if (pick < 80) begin
                k = $urandom_range(0, NSESS - 1);
                n = sb.sess_len[k];
                send_word(FUNC_READ, $urandom, $urandom, k,
                          ($urandom_range(0, 5) != 0 && n > 0) ? $urandom_range(0, n - 1)
                                                               : $urandom);
            end else if (pick < 90) begin
                k = $urandom_range(0, NSESS - 1);
                if (sb.sess_done[k] || sb.sess_id[k] == 0 || $urandom_range(0, 3) == 0)
                    send_word(FUNC_REL, $urandom, $urandom, k, $urandom);
            end else if (pick < 95) begin
                q = {};
                repeat ($urandom_range(1, 12)) q.push_back($urandom);
                if ($urandom_range(0, 1)) q[0] = $urandom_range(0, 3);
                send_bytes(q, 0);
            end else begin
                send_word(OP_NONE, $urandom, $urandom, $urandom, $urandom);
            end
        end
        steady = 0;
    endtask

    initial begin
        sb.clear();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        running = 1;
        @(posedge i_clk);
        directed();
        random_phase();
        drain();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
